// File: rtl/gsn_pkg.sv
// Shared types, constants and helpers for the grid seam neighbor step block.
`timescale 1ns / 1ps
`default_nettype none
package gsn_pkg;

	localparam int unsigned GRID_W        = 10;
	localparam int unsigned COORD_W       = 9;
	localparam int unsigned LINK_W        = 11;
	localparam int unsigned SIDE_W        = 2;
	localparam int unsigned MAX_GRIDS_DEF = 1024;
	localparam int unsigned MAX_SIDE      = 256;
	localparam int unsigned SIDE_MIN      = 2;
	localparam logic [COORD_W-1:0] SIDE_RESET = 9'd16;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		DIR_U_DEC = 2'd0,
		DIR_U_INC = 2'd1,
		DIR_V_DEC = 2'd2,
		DIR_V_INC = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		SIDE_LEFT   = 2'd0,
		SIDE_RIGHT  = 2'd1,
		SIDE_BOTTOM = 2'd2,
		SIDE_TOP    = 2'd3
	} side_t;

	typedef struct packed {
		logic              valid;
		logic [GRID_W-1:0] grid;
		side_t             side;
	} link_entry_t;

	typedef struct packed {
		logic               in_bounds;
		logic               grid_ok;
		logic [GRID_W-1:0]  grid;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
		logic [COORD_W-1:0] t;
	} step_info_t;

	typedef struct packed {
		logic               found;
		logic [GRID_W-1:0]  grid;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
	} step_result_t;

	function automatic logic [COORD_W-1:0] eff_side(input logic [COORD_W-1:0] side_max);
		logic [COORD_W-1:0] s;
		if ({23'b0, side_max} < 32'(SIDE_MIN)) begin
			s = COORD_W'(SIDE_MIN);
		end else if ({23'b0, side_max} > 32'(MAX_SIDE)) begin
			s = COORD_W'(MAX_SIDE);
		end else begin
			s = side_max;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// File: rtl/grid_seam_neighbor_step_core.sv
// Top level of the grid seam neighbor step block: link table, pipeline and handshakes.
//
// Input channel (in_valid / in_stall) carries write items (opcode 0), which load one
// link of the table, and step items (opcode 1), which return one result each on the
// output channel (out_valid / out_stall). Write items return nothing.
// One item is taken per cycle while in_stall is low. A step result reaches the output
// register by way of stage 1: its transfer loads stage 1 together with the registered
// link table read, which sets the first stage; stage 1 then loads the result register.
// A write is visible to a step transferred in the next cycle.
// After reset the link table is swept to unlinked, one entry per cycle, across all
// 4 * MAX_GRIDS entries (4096 by default); in_stall stays high during the sweep.
// side_max resets to 16 and may be written via cfg_wr_en / cfg_wr_data while idle.
// While out_stall is high the result holds, the middle stage fills, and then
// in_stall rises until the output register drains.
`timescale 1ns / 1ps
`default_nettype none
module grid_seam_neighbor_step_core #(
	parameter int unsigned MAX_GRIDS = gsn_pkg::MAX_GRIDS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [gsn_pkg::COORD_W-1:0]       cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [gsn_pkg::GRID_W-1:0]        grid,
	input  wire logic [gsn_pkg::COORD_W-1:0]       coord_u,
	input  wire logic [gsn_pkg::COORD_W-1:0]       coord_v,
	input  wire logic [gsn_pkg::SIDE_W-1:0]        direction,
	input  wire logic [gsn_pkg::SIDE_W-1:0]        own_side,
	input  wire logic signed [gsn_pkg::LINK_W-1:0] link_grid,
	input  wire logic [gsn_pkg::SIDE_W-1:0]        link_side,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   found,
	output logic [gsn_pkg::GRID_W-1:0]             out_grid,
	output logic [gsn_pkg::COORD_W-1:0]            out_u,
	output logic [gsn_pkg::COORD_W-1:0]            out_v
);
	import gsn_pkg::*;

	localparam int unsigned DEPTH = MAX_GRIDS * 4;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [COORD_W-1:0] side_max_q;
	logic [COORD_W-1:0] side_eff;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;
	logic               in_xfer;
	logic               is_step;
	logic               is_write;
	logic               s1_adv;
	logic               s1_valid_q;
	step_info_t         info;
	step_info_t         info_s1;
	side_t              exit_side;
	step_result_t       result;
	step_result_t       res_s2;
	logic               out_valid_q;
	link_entry_t        wr_entry;
	link_entry_t        rd_entry;
	logic               link_ok;
	logic [31:0]        wr_idx;
	logic [31:0]        rd_idx;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	link_entry_t        ram_wdata;
	logic               ram_re;

	assign side_eff = eff_side(side_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_max_q <= SIDE_RESET;
		end else if (cfg_wr_en) begin
			side_max_q <= cfg_wr_data;
		end
	end

	// clear the link table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = clr_busy_q || (s1_valid_q && !s1_adv);
	assign in_xfer  = in_valid && !in_stall;
	assign is_step  = in_xfer && (op_t'(opcode) == OP_STEP);
	assign is_write = in_xfer && (op_t'(opcode) == OP_WRITE);

	gsn_front #(
		.MAX_GRIDS(MAX_GRIDS)
	) u_front (
		.grid     (grid),
		.coord_u  (coord_u),
		.coord_v  (coord_v),
		.direction(dir_t'(direction)),
		.side_eff (side_eff),
		.info     (info),
		.exit_side(exit_side)
	);

	assign link_ok = !link_grid[LINK_W-1] &&
		({21'b0, $unsigned(link_grid)} < 32'(MAX_GRIDS));

	always_comb begin
		wr_entry = '0;
		if (link_ok) begin
			wr_entry.valid = 1'b1;
			wr_entry.grid  = link_grid[GRID_W-1:0];
			wr_entry.side  = side_t'(link_side);
		end
	end

	assign wr_idx = {20'b0, grid, own_side};
	assign rd_idx = {20'b0, grid, exit_side};

	assign ram_we    = clr_busy_q || (is_write && info.grid_ok);
	assign ram_waddr = clr_busy_q ? clr_addr_q : wr_idx[AW-1:0];
	assign ram_wdata = clr_busy_q ? link_entry_t'('0) : wr_entry;
	assign ram_re    = is_step;

	gsn_ram #(
		.WIDTH($bits(link_entry_t)),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx[AW-1:0]),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (is_step) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			info_s1 <= info;
		end
	end

	gsn_resolve u_resolve (
		.info    (info_s1),
		.entry   (rd_entry),
		.side_eff(side_eff),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			res_s2 <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = res_s2.found;
	assign out_grid  = res_s2.grid;
	assign out_u     = res_s2.u;
	assign out_v     = res_s2.v;

	a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_xfer)
		else $error("input transfer during table clear");

	a_step_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		is_step |=> s1_valid_q)
		else $error("step transfer did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(info_s1)))
		else $error("stage 1 lost an item while blocked");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (out_grid == '0 && out_u == '0 && out_v == '0))
		else $error("not found result carries nonzero fields");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(is_write && !s1_valid_q) |=> !s1_valid_q)
		else $error("write item produced a result");

endmodule
`default_nettype wire

// File: rtl/gsn_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gsn_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/gsn_front.sv
// Move the start point one unit and pick the exit side and seam parameter.
`timescale 1ns / 1ps
`default_nettype none
module gsn_front #(
	parameter int unsigned MAX_GRIDS = gsn_pkg::MAX_GRIDS_DEF
) (
	input  wire logic [gsn_pkg::GRID_W-1:0]  grid,
	input  wire logic [gsn_pkg::COORD_W-1:0] coord_u,
	input  wire logic [gsn_pkg::COORD_W-1:0] coord_v,
	input  wire gsn_pkg::dir_t               direction,
	input  wire logic [gsn_pkg::COORD_W-1:0] side_eff,
	output gsn_pkg::step_info_t              info,
	output gsn_pkg::side_t                   exit_side
);
	import gsn_pkg::*;

	logic signed [COORD_W+1:0] cu_x;
	logic signed [COORD_W+1:0] cv_x;
	logic signed [COORD_W+1:0] s_x;
	logic signed [COORD_W+1:0] u_m;
	logic signed [COORD_W+1:0] v_m;

	assign cu_x = $signed({2'b00, coord_u});
	assign cv_x = $signed({2'b00, coord_v});
	assign s_x  = $signed({2'b00, side_eff});

	always_comb begin
		u_m = cu_x;
		v_m = cv_x;
		unique case (direction)
			DIR_U_DEC: u_m = cu_x - 11'sd1;
			DIR_U_INC: u_m = cu_x + 11'sd1;
			DIR_V_DEC: v_m = cv_x - 11'sd1;
			DIR_V_INC: v_m = cv_x + 11'sd1;
			default:   u_m = cu_x;
		endcase
	end

	always_comb begin
		priority if (u_m < 11'sd0) begin
			exit_side = SIDE_LEFT;
		end else if (u_m > s_x) begin
			exit_side = SIDE_RIGHT;
		end else if (v_m < 11'sd0) begin
			exit_side = SIDE_BOTTOM;
		end else begin
			exit_side = SIDE_TOP;
		end
	end

	always_comb begin
		info.in_bounds = (u_m >= 11'sd0) && (u_m <= s_x) && (v_m >= 11'sd0) && (v_m <= s_x);
		info.grid_ok   = {22'b0, grid} < 32'(MAX_GRIDS);
		info.grid      = grid;
		info.u         = u_m[COORD_W-1:0];
		info.v         = v_m[COORD_W-1:0];
		info.t         = (exit_side == SIDE_LEFT || exit_side == SIDE_RIGHT) ? coord_v : coord_u;
	end

endmodule
`default_nettype wire

// File: rtl/gsn_resolve.sv
// Form the landing point from the moved point or the looked-up seam link.
`timescale 1ns / 1ps
`default_nettype none
module gsn_resolve (
	input  wire gsn_pkg::step_info_t         info,
	input  wire gsn_pkg::link_entry_t        entry,
	input  wire logic [gsn_pkg::COORD_W-1:0] side_eff,
	output gsn_pkg::step_result_t            result
);
	import gsn_pkg::*;

	logic [COORD_W-1:0] s_m1;

	assign s_m1 = side_eff - COORD_W'(1);

	always_comb begin
		result = '0;
		if (info.in_bounds) begin
			result.found = 1'b1;
			result.grid  = info.grid;
			result.u     = info.u;
			result.v     = info.v;
		end else if (info.grid_ok && entry.valid) begin
			result.found = 1'b1;
			result.grid  = entry.grid;
			unique case (entry.side)
				SIDE_LEFT: begin
					result.u = COORD_W'(1);
					result.v = info.t;
				end
				SIDE_RIGHT: begin
					result.u = s_m1;
					result.v = info.t;
				end
				SIDE_BOTTOM: begin
					result.u = info.t;
					result.v = COORD_W'(1);
				end
				SIDE_TOP: begin
					result.u = info.t;
					result.v = s_m1;
				end
				default: begin
					result.u = info.t;
					result.v = s_m1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: dv/grid_seam_neighbor_step_core_tb.sv
// Testbench for grid_seam_neighbor_step_core: seam link writes and lattice steps.
`timescale 1ns / 1ps
module grid_seam_neighbor_step_core_tb;
	import gsn_pkg::*;

	localparam int GRIDS       = MAX_GRIDS_DEF;
	localparam int PIPE_LAT    = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		op_t                      op;
		logic [GRID_W-1:0]        grid;
		logic [COORD_W-1:0]       u;
		logic [COORD_W-1:0]       v;
		dir_t                     dir;
		side_t                    own;
		logic signed [LINK_W-1:0] lgrid;
		side_t                    lside;
	} gsn_item_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [COORD_W-1:0]        cfg_wr_data = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic                      opcode      = 1'b0;
	logic [GRID_W-1:0]         grid        = '0;
	logic [COORD_W-1:0]        coord_u     = '0;
	logic [COORD_W-1:0]        coord_v     = '0;
	logic [SIDE_W-1:0]         direction   = '0;
	logic [SIDE_W-1:0]         own_side    = '0;
	logic signed [LINK_W-1:0]  link_grid   = '0;
	logic [SIDE_W-1:0]         link_side   = '0;
	logic                      out_valid;
	logic                      found;
	logic [GRID_W-1:0]         out_grid;
	logic [COORD_W-1:0]        out_u;
	logic [COORD_W-1:0]        out_v;

	logic rx_stall    = 1'b0;
	logic hold_stall  = 1'b0;
	logic rx_idle_en  = 1'b1;
	logic tx_idle_en  = 1'b1;
	int   rx_left     = 0;
	wire  out_stall   = rx_stall | hold_stall;

	link_entry_t  seam_links [0:GRIDS*4-1];
	logic [COORD_W-1:0] side_cfg = SIDE_RESET;
	step_result_t landing_q [$];
	step_result_t last_landing;
	step_result_t want;
	int grid_pool [8];

	int n_cycles       = 0;
	int n_items        = 0;
	int n_steps        = 0;
	int n_writes       = 0;
	int n_checked      = 0;
	int n_bad          = 0;
	int n_cfg          = 0;
	int n_backpressure = 0;

	grid_seam_neighbor_step_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.grid        (grid),
		.coord_u     (coord_u),
		.coord_v     (coord_v),
		.direction   (direction),
		.own_side    (own_side),
		.link_grid   (link_grid),
		.link_side   (link_side),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.out_grid    (out_grid),
		.out_u       (out_u),
		.out_v       (out_v)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				n_cycles, landing_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 2);
	endfunction

	function automatic int cur_side();
		int s;
		s = int'(side_cfg);
		if (s < int'(SIDE_MIN))
			s = SIDE_MIN;
		if (s > int'(MAX_SIDE))
			s = MAX_SIDE;
		return s;
	endfunction

	function automatic int pick_coord(input int s);
		case ($urandom_range(0, 11))
			0: return 0;
			1: return s;
			2: return 1;
			3: return s - 1;
			4: return $urandom_range(0, 511);
			default: return $urandom_range(0, s);
		endcase
	endfunction

	function automatic gsn_item_t make_step(input int g, input int u, input int v, input dir_t d);
		gsn_item_t it;
		it.op    = OP_STEP;
		it.grid  = g[GRID_W-1:0];
		it.u     = u[COORD_W-1:0];
		it.v     = v[COORD_W-1:0];
		it.dir   = d;
		it.own   = side_t'($urandom_range(0, 3));
		it.lgrid = LINK_W'($urandom_range(0, 2047));
		it.lside = side_t'($urandom_range(0, 3));
		return it;
	endfunction

	function automatic gsn_item_t make_link(input int g, input side_t own, input int lg,
			input side_t ls);
		gsn_item_t it;
		it.op    = OP_WRITE;
		it.grid  = g[GRID_W-1:0];
		it.u     = COORD_W'($urandom_range(0, 511));
		it.v     = COORD_W'($urandom_range(0, 511));
		it.dir   = dir_t'($urandom_range(0, 3));
		it.own   = own;
		it.lgrid = lg[LINK_W-1:0];
		it.lside = ls;
		return it;
	endfunction

	function automatic gsn_item_t seam_write();
		int roll, lg;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			lg = grid_pool[$urandom_range(0, 7)];
		else if (roll < 88)
			lg = $urandom_range(0, GRIDS - 1);
		else
			lg = -int'($urandom_range(1, 1024));
		return make_link(grid_pool[$urandom_range(0, 7)], side_t'($urandom_range(0, 3)), lg,
			side_t'($urandom_range(0, 3)));
	endfunction

	task automatic predict_landing(input gsn_item_t it);
		int s, pu, pv, t, nu, nv;
		side_t exit_side;
		link_entry_t lk;
		step_result_t res;
		if (it.op == OP_WRITE) begin
			n_writes++;
			if (int'(it.grid) < GRIDS) begin
				if (it.lgrid < 0 || int'(it.lgrid) >= GRIDS)
					seam_links[{it.grid, it.own}] = '0;
				else
					seam_links[{it.grid, it.own}] = '{1'b1, it.lgrid[GRID_W-1:0], it.lside};
			end
		end else begin
			n_steps++;
			s  = cur_side();
			pu = int'(it.u);
			pv = int'(it.v);
			case (it.dir)
				DIR_U_DEC: pu--;
				DIR_U_INC: pu++;
				DIR_V_DEC: pv--;
				default:   pv++;
			endcase
			if (pu >= 0 && pu <= s && pv >= 0 && pv <= s) begin
				res = '{1'b1, it.grid, pu[COORD_W-1:0], pv[COORD_W-1:0]};
			end else begin
				if (pu < 0) begin
					exit_side = SIDE_LEFT;
					t = int'(it.v);
				end else if (pu > s) begin
					exit_side = SIDE_RIGHT;
					t = int'(it.v);
				end else if (pv < 0) begin
					exit_side = SIDE_BOTTOM;
					t = int'(it.u);
				end else begin
					exit_side = SIDE_TOP;
					t = int'(it.u);
				end
				res = '0;
				if (int'(it.grid) < GRIDS) begin
					lk = seam_links[{it.grid, exit_side}];
					if (lk.valid) begin
						case (lk.side)
							SIDE_LEFT: begin
								nu = 1;
								nv = t;
							end
							SIDE_RIGHT: begin
								nu = s - 1;
								nv = t;
							end
							SIDE_BOTTOM: begin
								nu = t;
								nv = 1;
							end
							default: begin
								nu = t;
								nv = s - 1;
							end
						endcase
						res = '{1'b1, lk.grid, nu[COORD_W-1:0], nv[COORD_W-1:0]};
					end
				end
			end
			landing_q.push_back(res);
			last_landing = res;
		end
	endtask

	task automatic send_item(input gsn_item_t it);
		@(negedge clk);
		in_valid  = 1'b1;
		opcode    = it.op;
		grid      = it.grid;
		coord_u   = it.u;
		coord_v   = it.v;
		direction = it.dir;
		own_side  = it.own;
		link_grid = it.lgrid;
		link_side = it.lside;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_landing(it);
		n_items++;
	endtask

	task automatic push_item(input gsn_item_t it);
		int gap;
		send_item(it);
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk) in_valid = 1'b0;
		while (landing_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_side(input int val);
		wait_idle();
		@(negedge clk) begin
			cfg_wr_en   = 1'b1;
			cfg_wr_data = val[COORD_W-1:0];
		end
		@(negedge clk) cfg_wr_en = 1'b0;
		side_cfg = val[COORD_W-1:0];
		n_cfg++;
	endtask

	task automatic wire_pool();
		int k, sd;
		grid_pool[0] = 0;
		grid_pool[1] = GRIDS - 1;
		for (k = 2; k < 8; k++)
			grid_pool[k] = $urandom_range(0, GRIDS - 1);
		for (k = 0; k < 8; k++)
			for (sd = 0; sd < 4; sd++)
				push_item(make_link(grid_pool[k], side_t'(sd), grid_pool[$urandom_range(0, 7)],
					side_t'($urandom_range(0, 3))));
	endtask

	task automatic run_walks(input int count);
		int k, roll, g, cu, cv, s;
		dir_t heading;
		logic alive;
		alive   = 1'b0;
		heading = DIR_U_DEC;
		g  = 0;
		cu = 0;
		cv = 0;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			s    = cur_side();
			if (roll < 12) begin
				push_item(seam_write());
			end else if (roll < 17) begin
				push_item(make_step($urandom_range(0, GRIDS - 1), $urandom_range(0, 511),
					$urandom_range(0, 511), dir_t'($urandom_range(0, 3))));
			end else begin
				if (!alive || $urandom_range(0, 24) == 0) begin
					g  = grid_pool[$urandom_range(0, 7)];
					cu = pick_coord(s);
					cv = pick_coord(s);
				end
				if ($urandom_range(0, 3) == 0)
					heading = dir_t'($urandom_range(0, 3));
				push_item(make_step(g, cu, cv, heading));
				alive = last_landing.found;
				g  = int'(last_landing.grid);
				cu = int'(last_landing.u);
				cv = int'(last_landing.v);
			end
		end
	endtask

	task automatic test_unlinked_edges();
		push_item(make_step(0, 0, 5, DIR_U_DEC));
		push_item(make_step(GRIDS - 1, 16, 7, DIR_U_INC));
		push_item(make_step(0, 9, 0, DIR_V_DEC));
		push_item(make_step(GRIDS - 1, 3, 16, DIR_V_INC));
	endtask

	task automatic test_inner_moves();
		push_item(make_step(GRIDS - 1, 0, 0, DIR_U_INC));
		push_item(make_step(0, 16, 16, DIR_V_DEC));
		push_item(make_step(5, 8, 8, DIR_U_DEC));
		push_item(make_step(5, 8, 8, DIR_U_INC));
		push_item(make_step(5, 8, 8, DIR_V_DEC));
		push_item(make_step(5, 8, 8, DIR_V_INC));
		push_item(make_step(0, 511, 3, DIR_U_DEC));
		push_item(make_step(0, 3, 511, DIR_U_INC));
	endtask

	task automatic test_seam_links();
		push_item(make_link(0, SIDE_LEFT, GRIDS - 1, SIDE_RIGHT));
		push_item(make_link(0, SIDE_RIGHT, 1, SIDE_LEFT));
		push_item(make_link(0, SIDE_BOTTOM, 2, SIDE_TOP));
		push_item(make_link(0, SIDE_TOP, 3, SIDE_BOTTOM));
		push_item(make_step(0, 0, 11, DIR_U_DEC));
		push_item(make_step(0, 16, 4, DIR_U_INC));
		push_item(make_step(0, 13, 0, DIR_V_DEC));
		push_item(make_step(0, 2, 16, DIR_V_INC));
		push_item(make_link(0, SIDE_LEFT, -1, SIDE_TOP));
		push_item(make_link(0, SIDE_RIGHT, -1024, SIDE_BOTTOM));
		push_item(make_step(0, 0, 6, DIR_U_DEC));
		push_item(make_step(0, 16, 6, DIR_U_INC));
	endtask

	task automatic test_side_extremes();
		int side_sweep [10];
		int k;
		side_sweep = '{0, 1, 2, 3, 16, 128, 255, 256, 257, 511};
		wire_pool();
		for (k = 0; k < 10; k++) begin
			write_side(side_sweep[k]);
			run_walks(60);
		end
	endtask

	task automatic test_output_hold();
		int k;
		wait_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		fork
			begin
				@(negedge clk) hold_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_stall = 1'b0;
			end
			for (k = 0; k < 40; k++)
				push_item(make_step(grid_pool[$urandom_range(0, 7)], pick_coord(cur_side()),
					pick_coord(cur_side()), dir_t'($urandom_range(0, 3))));
		join
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_random_walks();
		int c;
		wait_idle();
		wire_pool();
		for (c = 0; c < 8; c++) begin
			case (c % 4)
				0: write_side($urandom_range(2, 40));
				1: write_side($urandom_range(0, 511));
				2: write_side(MAX_SIDE);
				default: write_side($urandom_range(3, 8));
			endcase
			tx_idle_en = (c % 3 != 2);
			rx_idle_en = (c % 3 != 1);
			run_walks(135);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	always @(negedge clk) begin
		if (!rx_idle_en) begin
			rx_stall <= 1'b0;
			rx_left  <= 0;
		end else if (rx_left > 0) begin
			rx_left <= rx_left - 1;
		end else begin
			rx_stall <= !rx_stall;
			rx_left  <= rx_stall ? $urandom_range(0, 5) : pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (landing_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: found=%0d grid=%0d u=%0d v=%0d",
						found, out_grid, out_u, out_v);
			end else begin
				want = landing_q.pop_front();
				n_checked++;
				if (found !== want.found || out_grid !== want.grid || out_u !== want.u
						|| out_v !== want.v) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("step result mismatch: want found=%0d grid=%0d u=%0d v=%0d",
							want.found, want.grid, want.u, want.v);
						$display("  got found=%0d grid=%0d u=%0d v=%0d",
							found, out_grid, out_u, out_v);
					end
				end
			end
		end
		if (arst_n && in_valid && in_stall)
			n_backpressure++;
	end

	initial begin
		for (int k = 0; k < GRIDS * 4; k++)
			seam_links[k] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_unlinked_edges();
		test_inner_moves();
		test_seam_links();
		test_side_extremes();
		test_output_hold();
		test_random_walks();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d input transfers (%0d steps, %0d link writes), %0d results checked.",
			n_items, n_steps, n_writes, n_checked);
		$display("Side register written %0d times; input held off on %0d cycles; %0d errors.",
			n_cfg, n_backpressure, n_bad);
		if (n_bad == 0 && landing_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/gsn_pkg.sv
rtl/gsn_ram.sv
rtl/gsn_front.sv
rtl/gsn_resolve.sv
rtl/grid_seam_neighbor_step_core.sv
dv/grid_seam_neighbor_step_core_tb.sv
